### src/ipv4_l4_checksum_check_fix_top_macros.svh
// Assertion macros for the IPv4 TCP/UDP checksum check and fix block.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef IPV4_L4_CHECKSUM_CHECK_FIX_TOP_MACROS_SVH
`define IPV4_L4_CHECKSUM_CHECK_FIX_TOP_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ICSUM_ASSERT_HOLD(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ICSUM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### src/icsum_pkg.sv
// Shared types, constants and the ones' complement adder for the checksum block.
// No dependencies; imported by every module of the block.
`default_nettype none

package icsum_pkg;

    typedef logic [16:0] pos_t;

    localparam pos_t        POS_MAX     = 17'h1ffff;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [3:0]  IP_V4       = 4'd4;
    localparam logic [15:0] SUM_OK      = 16'hffff;
    localparam logic [15:0] FRAG_MASK   = 16'h3fff;
    localparam logic [15:0] UDP_CK_OFF  = 16'd6;
    localparam logic [15:0] TCP_CK_OFF  = 16'd16;

    typedef enum logic [2:0] {
        CLS_FWD    = 3'd0,
        CLS_TRUNC  = 3'd1,
        CLS_NOT_IP = 3'd2,
        CLS_NOT_L4 = 3'd3,
        CLS_FRAG   = 3'd4
    } cls_t;

    typedef logic [0:0] cfg_idx_t;

    localparam cfg_idx_t CFG_RECOMPUTE_IP = 1'b0;
    localparam cfg_idx_t CFG_RECOMPUTE_L4 = 1'b1;

    typedef struct packed {
        logic recompute_ip;
        logic recompute_l4;
    } cfg_t;

    // Packet fields and sums captured at the last word
    typedef struct packed {
        pos_t        cap;
        logic [3:0]  ver;
        logic [3:0]  hw;
        logic [15:0] tot_len;
        logic [13:0] frag;
        logic [7:0]  proto;
        logic [3:0]  tcp_doff;
        logic [15:0] old_ip;
        logic [15:0] old_l4;
        logic [15:0] hdr_sum;
        logic [15:0] seg_sum;
    } snap_t;

    // Classification and folded sums handed to the fix stage
    typedef struct packed {
        cls_t        cls;
        logic        udp;
        logic        ip_ok;
        logic        l4_ok;
        logic [15:0] hdr_sum;
        logic [15:0] l4_sum;
        logic [15:0] covered;
        logic [15:0] old_ip;
        logic [15:0] old_l4;
    } chk_t;

    // 16-bit add with end-around carry; one carry pass is always enough
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

### src/icsum_if.sv
// Channel interfaces of the checksum block: packet words in, results out.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface icsum_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] data_word;
    logic        last_word;
    logic        odd_tail;

    modport source (output valid, output data_word, output last_word, output odd_tail,
                    input ready);
    modport sink   (input valid, input data_word, input last_word, input odd_tail,
                    output ready);
endinterface

interface icsum_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  packet_class;
    logic        is_udp;
    logic        ip_sum_ok;
    logic        l4_sum_ok;
    logic [15:0] ip_checksum_out;
    logic [15:0] l4_checksum_out;

    modport source (output valid, output packet_class, output is_udp, output ip_sum_ok,
                    output l4_sum_ok, output ip_checksum_out, output l4_checksum_out,
                    input ready);
    modport sink   (input valid, input packet_class, input is_udp, input ip_sum_ok,
                    input l4_sum_ok, input ip_checksum_out, input l4_checksum_out,
                    output ready);
endinterface

`default_nettype wire

### src/icsum_accum.sv
// Word accumulator: captures header fields and keeps ones' complement sums.
// Depends on icsum_pkg and icsum_word_if; registers a snapshot at the last word.
`default_nettype none

module icsum_accum import icsum_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    icsum_word_if.sink   words,
    input  wire logic    down_ready,
    output logic         snap_valid,
    output snap_t        snap
);

    pos_t        pos_reg,      pos_next;
    logic [15:0] hdr_sum_reg,  hdr_sum_next;
    logic [15:0] seg_sum_reg,  seg_sum_next;
    logic [3:0]  ver_reg,      ver_next;
    logic [3:0]  hw_reg,       hw_next;
    logic [15:0] tot_len_reg,  tot_len_next;
    logic [13:0] frag_reg,     frag_next;
    logic [7:0]  proto_reg,    proto_next;
    logic [3:0]  tcp_doff_reg, tcp_doff_next;
    logic [15:0] old_ip_reg,   old_ip_next;
    logic [15:0] old_l4_reg,   old_l4_next;

    logic        snap_valid_reg;
    snap_t       snap_reg;

    logic        half;
    logic [15:0] w;
    logic [5:0]  l3;
    pos_t        l3_ext;
    pos_t        off;
    logic [15:0] seg_mid;
    logic [15:0] seg_word;
    logic [17:0] pos_inc1;
    logic [17:0] pos_sum;
    logic        in_l4;
    logic        fire;

    assign words.ready = !snap_valid_reg || down_ready;
    assign fire        = words.valid && words.ready;

    always_comb
    begin
        half = words.last_word && words.odd_tail;
        w    = half ? {words.data_word[15:8], 8'h00} : words.data_word;

        ver_next     = (pos_reg == 17'd0)  ? w[15:12] : ver_reg;
        hw_next      = (pos_reg == 17'd0)  ? w[11:8]  : hw_reg;
        tot_len_next = (pos_reg == 17'd2)  ? w        : tot_len_reg;
        frag_next    = (pos_reg == 17'd6)  ? 14'(w & FRAG_MASK) : frag_reg;
        proto_next   = (pos_reg == 17'd8)  ? w[7:0]   : proto_reg;
        old_ip_next  = (pos_reg == 17'd10) ? w        : old_ip_reg;

        l3     = {hw_next, 2'b00};
        l3_ext = {11'd0, l3};

        hdr_sum_next = (pos_reg < l3_ext) ? ones_add(hdr_sum_reg, w) : hdr_sum_reg;

        // source and destination addresses feed the pseudo-header sum
        seg_mid = (pos_reg >= 17'd12 && pos_reg < 17'd20) ? ones_add(seg_sum_reg, w)
                                                           : seg_sum_reg;
        pos_inc1 = {1'b0, pos_reg} + 18'd1;
        seg_word = (pos_inc1 >= {2'b00, tot_len_next}) ? {w[15:8], 8'h00} : w;
        seg_sum_next = (pos_reg >= l3_ext && pos_reg < {1'b0, tot_len_next})
                     ? ones_add(seg_mid, seg_word) : seg_mid;

        off           = pos_reg - l3_ext;
        in_l4         = (pos_reg >= l3_ext) && (pos_reg != POS_MAX);
        tcp_doff_next = tcp_doff_reg;
        old_l4_next   = old_l4_reg;
        if (in_l4)
        begin
            if (proto_next == PROTO_TCP)
            begin
                if (off == 17'd12)
                    tcp_doff_next = w[15:12];
                else if (off == 17'd16)
                    old_l4_next = w;
            end
            else if (proto_next == PROTO_UDP && off == 17'd6)
            begin
                old_l4_next = w;
            end
        end

        // saturate the byte count
        pos_sum  = {1'b0, pos_reg} + (half ? 18'd1 : 18'd2);
        pos_next = (pos_sum > {1'b0, POS_MAX}) ? POS_MAX : pos_sum[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            hdr_sum_reg  <= '0;
            seg_sum_reg  <= '0;
            ver_reg      <= '0;
            hw_reg       <= '0;
            tot_len_reg  <= '0;
            frag_reg     <= '0;
            proto_reg    <= '0;
            tcp_doff_reg <= '0;
            old_ip_reg   <= '0;
            old_l4_reg   <= '0;
        end
        else if (fire)
        begin
            if (words.last_word)
            begin
                // clear for the next packet
                pos_reg      <= '0;
                hdr_sum_reg  <= '0;
                seg_sum_reg  <= '0;
                ver_reg      <= '0;
                hw_reg       <= '0;
                tot_len_reg  <= '0;
                frag_reg     <= '0;
                proto_reg    <= '0;
                tcp_doff_reg <= '0;
                old_ip_reg   <= '0;
                old_l4_reg   <= '0;
            end
            else
            begin
                pos_reg      <= pos_next;
                hdr_sum_reg  <= hdr_sum_next;
                seg_sum_reg  <= seg_sum_next;
                ver_reg      <= ver_next;
                hw_reg       <= hw_next;
                tot_len_reg  <= tot_len_next;
                frag_reg     <= frag_next;
                proto_reg    <= proto_next;
                tcp_doff_reg <= tcp_doff_next;
                old_ip_reg   <= old_ip_next;
                old_l4_reg   <= old_l4_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (words.ready)
            snap_valid_reg <= fire && words.last_word;
    end

    always_ff @(posedge clk)
    begin
        if (fire && words.last_word)
        begin
            snap_reg.cap      <= pos_next;
            snap_reg.ver      <= ver_next;
            snap_reg.hw       <= hw_next;
            snap_reg.tot_len  <= tot_len_next;
            snap_reg.frag     <= frag_next;
            snap_reg.proto    <= proto_next;
            snap_reg.tcp_doff <= tcp_doff_next;
            snap_reg.old_ip   <= old_ip_next;
            snap_reg.old_l4   <= old_l4_next;
            snap_reg.hdr_sum  <= hdr_sum_next;
            snap_reg.seg_sum  <= seg_sum_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

`default_nettype wire

### src/icsum_check.sv
// Check stage: classifies the packet and folds the pseudo-header sum.
// Depends on icsum_pkg; fed by the accumulator snapshot, feeds the fix stage.
`default_nettype none

module icsum_check import icsum_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  snap_valid,
    input  snap_t      snap,
    output logic       ready,
    input  wire logic  down_ready,
    output logic       chk_valid,
    output chk_t       chk
);

    logic        chk_valid_reg;
    chk_t        chk_reg;
    chk_t        chk_next;

    logic [5:0]  l3;
    pos_t        l3_ext;
    pos_t        rem;
    logic [15:0] l4len;
    logic [5:0]  doff_bytes;
    logic [15:0] s1;
    logic [15:0] cs_off;
    cls_t        cls;
    logic        udp;

    assign ready = !chk_valid_reg || down_ready;

    always_comb
    begin
        l3         = {snap.hw, 2'b00};
        l3_ext     = {11'd0, l3};
        rem        = snap.cap - l3_ext;
        l4len      = snap.tot_len - {10'd0, l3};
        doff_bytes = {snap.tcp_doff, 2'b00};
        udp        = (snap.proto == PROTO_UDP);

        if (snap.cap < 17'd20)
            cls = CLS_TRUNC;
        else if (snap.ver != IP_V4)
            cls = CLS_NOT_IP;
        else if (snap.proto != PROTO_TCP && snap.proto != PROTO_UDP)
            cls = CLS_NOT_L4;
        else if (l3 < 6'd20 || snap.cap < l3_ext)
            cls = CLS_TRUNC;
        else if (snap.frag != 14'd0)
            cls = CLS_FRAG;
        else if (snap.tot_len < {10'd0, l3})
            cls = CLS_TRUNC;
        else if (rem < {1'b0, l4len})
            cls = CLS_TRUNC;
        else if (udp)
            cls = (rem < 17'd8) ? CLS_TRUNC : CLS_FWD;
        else if (rem < 17'd20 || snap.tcp_doff < 4'd5 || rem < {11'd0, doff_bytes})
            cls = CLS_TRUNC;
        else
            cls = CLS_FWD;

        s1 = ones_add(snap.seg_sum, {8'd0, snap.proto});

        chk_next.cls     = cls;
        chk_next.udp     = udp;
        chk_next.hdr_sum = snap.hdr_sum;
        chk_next.ip_ok   = (snap.hdr_sum == SUM_OK);
        chk_next.l4_sum  = ones_add(s1, l4len);
        chk_next.l4_ok   = (chk_next.l4_sum == SUM_OK) || (udp && snap.old_l4 == 16'd0);
        chk_next.old_ip  = snap.old_ip;
        chk_next.old_l4  = snap.old_l4;

        // only the part of the checksum field inside the segment counts
        cs_off = udp ? UDP_CK_OFF : TCP_CK_OFF;
        if (l4len >= cs_off + 16'd2)
            chk_next.covered = snap.old_l4;
        else if (l4len == cs_off + 16'd1)
            chk_next.covered = {snap.old_l4[15:8], 8'h00};
        else
            chk_next.covered = 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chk_valid_reg <= 1'b0;
        else if (ready)
            chk_valid_reg <= snap_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready && snap_valid)
            chk_reg <= chk_next;
    end

    assign chk_valid = chk_valid_reg;
    assign chk       = chk_reg;

endmodule

`default_nettype wire

### src/icsum_fix.sv
// Fix stage: recomputes each checksum when its cfg bit is set and drives the registered result beat.
// Depends on icsum_pkg and icsum_result_if; fed by the check stage.
`default_nettype none

module icsum_fix import icsum_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     chk_valid,
    input  chk_t          chk,
    input  cfg_t          cfg,
    output logic          ready,
    icsum_result_if.source result
);

    logic        valid_reg;
    cls_t        cls_reg;
    logic        udp_reg;
    logic        ip_ok_reg,  ip_ok_next;
    logic        l4_ok_reg,  l4_ok_next;
    logic [15:0] ip_cs_reg,  ip_cs_next;
    logic [15:0] l4_cs_reg,  l4_cs_next;

    logic [15:0] ip_r;
    logic [15:0] l4_r0;
    logic [15:0] l4_r1;

    assign ready = !valid_reg || result.ready;

    always_comb
    begin
        ip_r  = ~ones_add(chk.hdr_sum, ~chk.old_ip) + {15'd0, !chk.ip_ok};
        l4_r0 = ~ones_add(chk.l4_sum, ~chk.covered);
        // a zero UDP checksum means none; send all ones instead
        l4_r1 = (chk.udp && l4_r0 == 16'd0) ? 16'hffff : l4_r0;

        if (chk.cls == CLS_FWD)
        begin
            ip_ok_next = chk.ip_ok;
            l4_ok_next = chk.l4_ok;
            ip_cs_next = cfg.recompute_ip ? ip_r : chk.old_ip;
            l4_cs_next = cfg.recompute_l4 ? (l4_r1 + {15'd0, !chk.l4_ok}) : chk.old_l4;
        end
        else
        begin
            ip_ok_next = 1'b0;
            l4_ok_next = 1'b0;
            ip_cs_next = 16'd0;
            l4_cs_next = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready)
            valid_reg <= chk_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready && chk_valid)
        begin
            cls_reg   <= chk.cls;
            udp_reg   <= chk.udp;
            ip_ok_reg <= ip_ok_next;
            l4_ok_reg <= l4_ok_next;
            ip_cs_reg <= ip_cs_next;
            l4_cs_reg <= l4_cs_next;
        end
    end

    assign result.valid           = valid_reg;
    assign result.packet_class    = cls_reg;
    assign result.is_udp          = udp_reg;
    assign result.ip_sum_ok       = ip_ok_reg;
    assign result.l4_sum_ok       = l4_ok_reg;
    assign result.ip_checksum_out = ip_cs_reg;
    assign result.l4_checksum_out = l4_cs_reg;

endmodule

`default_nettype wire

### src/ipv4_l4_checksum_check_fix_top.sv
// Channel   Dir  Beat                                   Accepted when
// words     in   data_word, last_word, odd_tail         words.valid && words.ready
// result    out  class, is_udp, sum flags, checksums    result.valid && result.ready
// cfg       in   cfg_index, cfg_data                    cfg_we
//
// One packet word per cycle while words.ready is high; the ones' complement accumulator then takes a word every clock.
// After the last word, a result beat passes in turn through the snapshot, check and fix registers.
// Reset clears the accumulator and pipeline valids and sets both recompute bits.
// words.ready drops only when all three pipeline registers hold beats and result stalls.
// Depends on icsum_pkg, icsum_if, icsum_accum, icsum_check, icsum_fix and the macro header.
`default_nettype none
`include "ipv4_l4_checksum_check_fix_top_macros.svh"

module ipv4_l4_checksum_check_fix_top import icsum_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    icsum_word_if.sink     words,
    icsum_result_if.source result,
    input  wire logic      cfg_we,
    input  cfg_idx_t       cfg_index,
    input  wire logic      cfg_data
);

    cfg_t  cfg_reg;
    logic  snap_valid;
    snap_t snap;
    logic  chk_ready;
    logic  chk_valid;
    chk_t  chk;
    logic  fix_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.recompute_ip <= 1'b1;
            cfg_reg.recompute_l4 <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RECOMPUTE_IP: cfg_reg.recompute_ip <= cfg_data;
                CFG_RECOMPUTE_L4: cfg_reg.recompute_l4 <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    icsum_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .words      (words),
        .down_ready (chk_ready),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    icsum_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap       (snap),
        .ready      (chk_ready),
        .down_ready (fix_ready),
        .chk_valid  (chk_valid),
        .chk        (chk)
    );

    icsum_fix u_fix (
        .clk       (clk),
        .rst_n     (rst_n),
        .chk_valid (chk_valid),
        .chk       (chk),
        .cfg       (cfg_reg),
        .ready     (fix_ready),
        .result    (result)
    );

    // Input may stall only behind a stalled result beat
    `ICSUM_ASSERT_IMPLY(a_stall_from_out, !words.ready, result.valid && !result.ready, "input stalled while result side is free")
    // Dropped packets carry no check flags or checksums
    `ICSUM_ASSERT_IMPLY(a_drop_zero, result.valid && result.packet_class != CLS_FWD, !result.ip_sum_ok && !result.l4_sum_ok && result.ip_checksum_out == 16'd0 && result.l4_checksum_out == 16'd0, "non-forwarded beat has nonzero check fields")
    // A valid recomputed UDP checksum is never sent as zero
    `ICSUM_ASSERT_IMPLY(a_udp_nonzero, result.valid && result.packet_class == CLS_FWD && result.is_udp && result.l4_sum_ok && cfg_reg.recompute_l4, result.l4_checksum_out != 16'd0, "recomputed UDP checksum is zero")

endmodule

`default_nettype wire

### dv/ipv4_l4_checksum_check_fix_top_tb.sv
// Testbench for the IPv4 TCP/UDP checksum check and fix block: streams packets as word beats,
// predicts class, checksum flags and rewritten checksums, and checks every result beat.
// Depends on icsum_pkg, icsum_if and the RTL of ipv4_l4_checksum_check_fix_top.
module ipv4_l4_checksum_check_fix_top_tb;
    import icsum_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        cls_t        cls;
        logic        udp;
        logic        ip_ok;
        logic        l4_ok;
        logic [15:0] ip_ck;
        logic [15:0] l4_ck;
    } verdict_t;

    typedef struct packed {
        logic [15:0] dw;
        logic        lw;
        logic        ot;
        logic        typed;
        cls_t        cls;
        logic        udp;
    } stim_row_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    logic     cfg_data;

    icsum_word_if   words_ch ();
    icsum_result_if result_ch ();

    ipv4_l4_checksum_check_fix_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .words     (words_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state, one packet at a time
    logic        fix_ip;
    logic        fix_l4;
    logic [16:0] pk_pos;
    logic [15:0] pk_hsum;
    logic [15:0] pk_ssum;
    logic [3:0]  pk_ver;
    logic [3:0]  pk_ihl;
    logic [15:0] pk_tlen;
    logic [13:0] pk_frag;
    logic [7:0]  pk_proto;
    logic [3:0]  pk_doff;
    logic [15:0] pk_old_ip;
    logic [15:0] pk_old_l4;

    verdict_t    pending_verdicts[$];
    logic [7:0]  pkt_bytes[$];
    stim_row_t   opening_rows [0:25];
    int          mismatches = 0;
    int          stuck_cycles = 0;
    int          words_sent = 0;
    int          results_due = 0;
    bit          quiet = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [15:0] endaround(input int unsigned s);
        while (s > 32'hffff)
            s = (s & 32'hffff) + (s >> 16);
        return 16'(s);
    endfunction

    function automatic void clear_tracker();
        pk_pos = '0; pk_hsum = '0; pk_ssum = '0; pk_ver = '0; pk_ihl = '0;
        pk_tlen = '0; pk_frag = '0; pk_proto = '0; pk_doff = '0;
        pk_old_ip = '0; pk_old_l4 = '0;
    endfunction

    function automatic cls_t class_of();
        int unsigned cap, l3, l4len, rem;
        cap = pk_pos;
        l3 = 32'(pk_ihl) * 4;
        if (cap < 20) return CLS_TRUNC;
        if (pk_ver != IP_V4) return CLS_NOT_IP;
        if (pk_proto != PROTO_TCP && pk_proto != PROTO_UDP) return CLS_NOT_L4;
        if (l3 < 20 || cap < l3) return CLS_TRUNC;
        if (pk_frag != '0) return CLS_FRAG;
        if (pk_tlen < l3) return CLS_TRUNC;
        l4len = pk_tlen - l3;
        rem = cap - l3;
        if (rem < l4len) return CLS_TRUNC;
        if (pk_proto == PROTO_UDP) return (rem < 8) ? CLS_TRUNC : CLS_FWD;
        if (rem < 20 || pk_doff < 5 || rem < 32'(pk_doff) * 4) return CLS_TRUNC;
        return CLS_FWD;
    endfunction

    // Advance the packet by one word beat; returns 1 when the beat closes the packet
    function automatic bit track_word(input logic [15:0] dw, input logic lw, input logic ot,
                                      output verdict_t v);
        int unsigned w, p, l3, off, seg_v, l4len, cs_off, covered, s, r;
        logic [15:0] ipf;
        bit half, udp, ip_ok, l4_ok;
        half = lw && ot;
        w = dw;
        if (half) w = w & 32'hff00;
        p = pk_pos;
        if (p == 0)
        begin
            pk_ver = 4'(w >> 12);
            pk_ihl = 4'(w >> 8);
        end
        else if (p == 2) pk_tlen = 16'(w);
        else if (p == 6) pk_frag = 14'(w & 32'(FRAG_MASK));
        else if (p == 8) pk_proto = 8'(w);
        else if (p == 10) pk_old_ip = 16'(w);

        l3 = 32'(pk_ihl) * 4;
        if (p < l3) pk_hsum = endaround(pk_hsum + w);
        if (p >= 12 && p < 20) pk_ssum = endaround(pk_ssum + w);
        // drop bytes past total length; an odd end pads with a zero low byte
        if (p >= l3 && p < pk_tlen)
        begin
            seg_v = w;
            if (p + 1 >= pk_tlen) seg_v = seg_v & 32'hff00;
            pk_ssum = endaround(pk_ssum + seg_v);
        end
        if (p >= l3 && p < POS_MAX)
        begin
            off = p - l3;
            if (pk_proto == PROTO_TCP)
            begin
                if (off == 12) pk_doff = 4'(w >> 12);
                else if (off == 16) pk_old_l4 = 16'(w);
            end
            else if (pk_proto == PROTO_UDP && off == 6)
                pk_old_l4 = 16'(w);
        end
        p = p + (half ? 1 : 2);
        pk_pos = (p > POS_MAX) ? POS_MAX : 17'(p);

        v = '0;
        if (!lw) return 1'b0;

        v.cls = class_of();
        udp = (pk_proto == PROTO_UDP);
        v.udp = udp;
        if (v.cls == CLS_FWD)
        begin
            ipf = endaround(pk_hsum);
            ip_ok = (ipf == SUM_OK);
            l4len = pk_tlen - l3;
            cs_off = udp ? UDP_CK_OFF : TCP_CK_OFF;
            s = endaround(32'(pk_ssum) + 32'(pk_proto));
            s = endaround(s + l4len);
            l4_ok = (s == SUM_OK) || (udp && pk_old_l4 == '0);
            if (fix_ip)
            begin
                r = ~endaround(32'(ipf) + (~32'(pk_old_ip) & 32'hffff)) & 32'hffff;
                if (!ip_ok) r = (r + 1) & 32'hffff;
            end
            else
                r = pk_old_ip;
            v.ip_ck = 16'(r);
            if (fix_l4)
            begin
                // only the part of the checksum field inside the segment counts
                if (l4len >= cs_off + 2) covered = pk_old_l4;
                else if (l4len == cs_off + 1) covered = pk_old_l4 & 16'hff00;
                else covered = 0;
                r = ~endaround(s + (~covered & 32'hffff)) & 32'hffff;
                if (udp && r == 0) r = 32'hffff;
                if (!l4_ok) r = (r + 1) & 32'hffff;
            end
            else
                r = pk_old_l4;
            v.l4_ck = 16'(r);
            v.ip_ok = ip_ok;
            v.l4_ok = l4_ok;
        end
        clear_tracker();
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        mismatches++;
        if (mismatches <= 100)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    task automatic apply_recompute(input logic ip, input logic l4);
        cfg_we <= 1'b1;
        cfg_index <= CFG_RECOMPUTE_IP;
        cfg_data <= ip;
        @(posedge clk);
        cfg_index <= CFG_RECOMPUTE_L4;
        cfg_data <= l4;
        @(posedge clk);
        cfg_we <= 1'b0;
        fix_ip = ip;
        fix_l4 = l4;
    endtask

    task automatic feed_word(input logic [15:0] dw, input logic lw, input logic ot,
                             output bit got, output verdict_t v);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            words_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        words_ch.valid <= 1'b1;
        words_ch.data_word <= dw;
        words_ch.last_word <= lw;
        words_ch.odd_tail <= ot;
        do
            @(posedge clk);
        while (!words_ch.ready);
        words_sent++;
        got = track_word(dw, lw, ot, v);
        if (got) results_due++;
    endtask

    task automatic feed_packet();
        int n, nw, i;
        logic [7:0] lo;
        logic lw, ot;
        bit got;
        verdict_t v;
        n = pkt_bytes.size();
        nw = (n + 1) / 2;
        for (i = 0; i < nw; i++)
        begin
            lo = (2 * i + 1 < n) ? pkt_bytes[2 * i + 1] : 8'($urandom);
            lw = (i == nw - 1);
            ot = lw ? n[0] : 1'($urandom);
            feed_word({pkt_bytes[2 * i], lo}, lw, ot, got, v);
            if (got) pending_verdicts.push_back(v);
        end
    endtask

    task automatic wait_drained();
        words_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] wire_sum(input logic [7:0] q[$], input int first,
                                             input int count, input int unsigned seed);
        int unsigned acc;
        int i;
        acc = seed;
        for (i = 0; i < count; i += 2)
            acc += {q[first + i], (i + 1 < count) ? q[first + i + 1] : 8'h00};
        return endaround(acc);
    endfunction

    // Mostly well-formed IPv4 TCP/UDP packets with random content, some noise and broken ones
    task automatic make_packet();
        logic [7:0] hdr[$];
        logic [7:0] seg[$];
        int roll, ihl, ver, seg_len, tot, l4len, cov_len, cs_off, i, opt_words, cut;
        logic [7:0] proto;
        logic [3:0] doff;
        logic [15:0] frag_w, ck;
        pkt_bytes.delete();
        roll = $urandom_range(0, 99);
        if (roll < 12)
        begin
            repeat ($urandom_range(1, 40)) pkt_bytes.push_back(8'($urandom));
            return;
        end
        ver = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 15) : IP_V4;
        if ($urandom_range(0, 9) == 0) ihl = $urandom_range(0, 15);
        else if ($urandom_range(0, 3) == 0) ihl = $urandom_range(6, 9);
        else ihl = 5;
        roll = $urandom_range(0, 9);
        proto = (roll == 0) ? 8'($urandom) : (roll < 6) ? PROTO_UDP : PROTO_TCP;
        frag_w = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                             : {2'($urandom), 14'd0};

        if (proto == PROTO_UDP)
            seg_len = 8 + $urandom_range(0, 24);
        else if (proto == PROTO_TCP)
        begin
            opt_words = $urandom_range(0, 3);
            seg_len = 20 + 4 * opt_words + $urandom_range(0, 24);
        end
        else
            seg_len = $urandom_range(0, 30);
        repeat (seg_len) seg.push_back(8'($urandom));
        cs_off = (proto == PROTO_UDP) ? UDP_CK_OFF : TCP_CK_OFF;
        if (proto == PROTO_UDP)
        begin
            seg[4] = 8'(seg_len >> 8);
            seg[5] = 8'(seg_len);
        end
        if (proto == PROTO_TCP)
        begin
            doff = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'(5 + opt_words);
            seg[12] = {doff, seg[12][3:0]};
        end
        if (proto == PROTO_UDP || proto == PROTO_TCP)
        begin
            seg[cs_off] = 8'h00;
            seg[cs_off + 1] = 8'h00;
        end

        repeat (20 + 4 * ((ihl > 5) ? ihl - 5 : 0)) hdr.push_back(8'($urandom));
        roll = $urandom_range(0, 31);
        if (roll < 4) tot = $urandom_range(0, hdr.size() + seg_len);
        else if (roll < 6) tot = hdr.size() + seg_len + $urandom_range(1, 20);
        else if (roll == 6) tot = $urandom_range(0, 65535);
        else tot = hdr.size() + seg_len;
        hdr[0] = {4'(ver), 4'(ihl)};
        hdr[2] = 8'(tot >> 8);
        hdr[3] = 8'(tot);
        hdr[6] = frag_w[15:8];
        hdr[7] = frag_w[7:0];
        hdr[9] = proto;
        hdr[10] = 8'h00;
        hdr[11] = 8'h00;

        if ((proto == PROTO_UDP || proto == PROTO_TCP) && seg_len >= cs_off + 2)
        begin
            l4len = (tot >= 4 * ihl) ? tot - 4 * ihl : 0;
            cov_len = (l4len < seg_len) ? l4len : seg_len;
            ck = ~wire_sum(seg, 0, cov_len,
                           wire_sum(hdr, 12, 8, 0) + proto + (l4len & 32'hffff));
            if (proto == PROTO_UDP && ck == 16'h0000) ck = 16'hffff;
            roll = $urandom_range(0, 9);
            if (roll == 7) ck = 16'h0000;
            else if (roll > 7) ck = 16'($urandom);
            seg[cs_off] = ck[15:8];
            seg[cs_off + 1] = ck[7:0];
        end
        ck = ($urandom_range(0, 6) == 0) ? 16'($urandom) : ~wire_sum(hdr, 0, hdr.size(), 0);
        hdr[10] = ck[15:8];
        hdr[11] = ck[7:0];

        pkt_bytes = {hdr, seg};
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            cut = $urandom_range(1, pkt_bytes.size());
            while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
        end
        else if (roll == 1)
            repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom));
    endtask

    initial
    begin
        result_ch.ready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        verdict_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_verdicts.size() == 0)
                note_mismatch("result beat with nothing pending", result_ch.packet_class, 0);
            else
            begin
                want = pending_verdicts.pop_front();
                if (result_ch.packet_class != want.cls)
                    note_mismatch("packet_class", result_ch.packet_class, want.cls);
                if (result_ch.is_udp != want.udp)
                    note_mismatch("is_udp", result_ch.is_udp, want.udp);
                if (result_ch.ip_sum_ok != want.ip_ok)
                    note_mismatch("ip_sum_ok", result_ch.ip_sum_ok, want.ip_ok);
                if (result_ch.l4_sum_ok != want.l4_ok)
                    note_mismatch("l4_sum_ok", result_ch.l4_sum_ok, want.l4_ok);
                if (result_ch.ip_checksum_out != want.ip_ck)
                    note_mismatch("ip_checksum_out", result_ch.ip_checksum_out, want.ip_ck);
                if (result_ch.l4_checksum_out != want.l4_ck)
                    note_mismatch("l4_checksum_out", result_ch.l4_checksum_out, want.l4_ck);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((words_ch.valid && words_ch.ready) || (result_ch.valid && result_ch.ready))
            stuck_cycles <= 0;
        else if (stuck_cycles + 1 >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin : stimulus
        logic [1:0] settings [0:3];
        int ph, i, word_goal, result_goal;
        bit got;
        verdict_t v;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_RECOMPUTE_IP;
        cfg_data = 1'b0;
        words_ch.valid = 1'b0;
        words_ch.data_word = '0;
        words_ch.last_word = 1'b0;
        words_ch.odd_tail = 1'b0;
        fix_ip = 1'b1;
        fix_l4 = 1'b1;
        clear_tracker();
        settings = '{2'b00, 2'b10, 2'b01, 2'b11};

        // single-word packets, a minimal UDP packet with zero checksum, a version 6 header
        opening_rows = '{
            '{16'h0000, 1'b1, 1'b0, 1'b1, CLS_TRUNC,  1'b0},
            '{16'hffff, 1'b1, 1'b1, 1'b1, CLS_TRUNC,  1'b0},
            '{16'h4500, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h001c, 1'b0, 1'b1, 1'b0, CLS_FWD,    1'b0},
            '{16'h1234, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h0000, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h4011, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'he749, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'hc0a8, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h0001, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'hc0a8, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h0002, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h0035, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h0035, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h0008, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h0000, 1'b1, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h6500, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h0028, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h0000, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h0000, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h4006, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h0000, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h0a00, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h0001, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h0a00, 1'b0, 1'b0, 1'b0, CLS_FWD,    1'b0},
            '{16'h0002, 1'b1, 1'b0, 1'b1, CLS_NOT_IP, 1'b0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apply_recompute(1'b1, 1'b1);

        for (i = 0; i < 26; i++)
        begin
            feed_word(opening_rows[i].dw, opening_rows[i].lw, opening_rows[i].ot, got, v);
            if (got && opening_rows[i].typed)
                pending_verdicts.push_back({opening_rows[i].cls, opening_rows[i].udp,
                                            1'b0, 1'b0, 16'h0000, 16'h0000});
            else if (got)
                pending_verdicts.push_back(v);
        end

        for (ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            apply_recompute(settings[ph][1], settings[ph][0]);
            quiet = (ph == 3);
            word_goal = words_sent + 225;
            result_goal = results_due + 12;
            while (words_sent < word_goal || results_due < result_goal)
            begin
                make_packet();
                feed_packet();
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/icsum_pkg.sv
src/icsum_if.sv
src/icsum_accum.sv
src/icsum_check.sv
src/icsum_fix.sv
src/ipv4_l4_checksum_check_fix_top.sv
dv/ipv4_l4_checksum_check_fix_top_tb.sv
